### design/rwlm_pkg.sv
package rwlm_pkg;

   localparam int DEFAULT_QUEUE_DEPTH  = 16;
   localparam int DEFAULT_TASK_ID_BITS = 8;

   localparam int          READER_BITS = 8;
   localparam logic [7:0]  READER_MAX  = 8'd255;

   typedef enum logic [1:0] {
      OP_READ    = 2'd0,
      OP_WRITE   = 2'd1,
      OP_RELEASE = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_FREE  = 2'd0,
      MODE_READ  = 2'd1,
      MODE_WRITE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_WAKE
   } state_type;

endpackage

### design/rwlm_ram.sv
module rwlm_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/reader_writer_lock_manager.sv
// A write grant or a refusal is registered onto rsp from the decide state; a read grant
// passes through the wake state and is registered onto rsp from there. A new request is taken
// once the previous one is finished, and each further reader woken from the queue adds one
// more response from the wake state, paced by the registered queue memory read.
// Synchronous active-high reset frees the lock and empties the queue; the queue memory itself
// is not cleared, as only entries that have been written are ever read.
module reader_writer_lock_manager #(
   parameter int QUEUE_DEPTH  = rwlm_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int TASK_ID_BITS = rwlm_pkg::DEFAULT_TASK_ID_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((TASK_ID_BITS+7)/8)*8-1:0]     req_tdata,   // task_id
   input  logic [1:0]                            req_tuser,   // opcode
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((TASK_ID_BITS+7)/8)*8-1:0]     rsp_tdata,   // granted_task
   output logic [1:0]                            rsp_tuser,   // refused, grant_is_write
   output logic                                  rsp_tlast
);

   localparam int TDATA_W = ((TASK_ID_BITS + 7) / 8) * 8;
   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W = TASK_ID_BITS + 1;

   rwlm_pkg::state_type  state_ff, state_in;
   rwlm_pkg::opcode_type op_ff, op_in;
   rwlm_pkg::mode_type   mode_ff, mode_in;

   logic [TASK_ID_BITS-1:0]          task_ff, task_in;
   logic [TASK_ID_BITS-1:0]          pend_ff, pend_in;
   logic [rwlm_pkg::READER_BITS-1:0] rc_ff, rc_in;
   logic [PTR_W-1:0]                 head_ff, head_in;
   logic [PTR_W-1:0]                 tail_ff, tail_in;
   logic [CNT_W-1:0]                 count_ff, count_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [TASK_ID_BITS-1:0] rsp_task_ff, rsp_task_in;
   logic                    rsp_write_ff, rsp_write_in;
   logic                    rsp_refused_ff, rsp_refused_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    mem_we;
   logic [ENTRY_W-1:0]      mem_wdata;
   logic [ENTRY_W-1:0]      mem_rdata;
   logic                    head_kind;
   logic [TASK_ID_BITS-1:0] head_task;
   logic                    nonempty, full, out_free, req_fire;
   logic                    emit, emit_write, emit_refused, emit_last;
   logic [TASK_ID_BITS-1:0] emit_task;
   logic                    go_wake, wake_more;
   logic                    enq_kind;

   assign req_fire  = req_tvalid && req_tready;
   assign nonempty  = count_ff != '0;
   assign full      = count_ff == CNT_W'(QUEUE_DEPTH);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign head_kind = mem_rdata[TASK_ID_BITS];
   assign head_task = mem_rdata[TASK_ID_BITS-1:0];
   assign wake_more = nonempty && !head_kind && (rc_ff < rwlm_pkg::READER_MAX);

   rwlm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (tail_ff),
      .wr_data (mem_wdata),
      .rd_addr (head_in),
      .rd_data (mem_rdata)
   );

   assign mem_wdata = {enq_kind, task_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rwlm_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = rwlm_pkg::ST_DECIDE;
            end
         end
         rwlm_pkg::ST_DECIDE: begin
            if (out_free) begin
               state_in = go_wake ? rwlm_pkg::ST_WAKE : rwlm_pkg::ST_IDLE;
            end
         end
         rwlm_pkg::ST_WAKE: begin
            if (out_free && !wake_more) begin
               state_in = rwlm_pkg::ST_IDLE;
            end
         end
         default: state_in = rwlm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      op_in        = op_ff;
      task_in      = task_ff;
      pend_in      = pend_ff;
      mode_in      = mode_ff;
      rc_in        = rc_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      mem_we       = 1'b0;
      enq_kind     = 1'b0;
      emit         = 1'b0;
      emit_task    = task_ff;
      emit_write   = 1'b0;
      emit_refused = 1'b0;
      emit_last    = 1'b1;
      go_wake      = 1'b0;

      unique case (state_ff)
         rwlm_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in   = rwlm_pkg::opcode_type'(req_tuser);
               task_in = req_tdata[TASK_ID_BITS-1:0];
            end
         end
         rwlm_pkg::ST_DECIDE: begin
            if (out_free) begin
               unique case (op_ff)
                  rwlm_pkg::OP_READ: begin
                     if (mode_ff == rwlm_pkg::MODE_WRITE ||
                         (mode_ff == rwlm_pkg::MODE_READ && nonempty && head_kind)) begin
                        if (full) begin
                           emit         = 1'b1;
                           emit_refused = 1'b1;
                        end else begin
                           mem_we = 1'b1;
                        end
                     end else if (rc_ff == rwlm_pkg::READER_MAX) begin
                        emit         = 1'b1;
                        emit_refused = 1'b1;
                     end else begin
                        rc_in   = rc_ff + 1'b1;
                        mode_in = rwlm_pkg::MODE_READ;
                        pend_in = task_ff;
                        go_wake = 1'b1;
                     end
                  end
                  rwlm_pkg::OP_WRITE: begin
                     if (mode_ff != rwlm_pkg::MODE_FREE) begin
                        if (full) begin
                           emit         = 1'b1;
                           emit_refused = 1'b1;
                        end else begin
                           mem_we   = 1'b1;
                           enq_kind = 1'b1;
                        end
                     end else begin
                        mode_in    = rwlm_pkg::MODE_WRITE;
                        emit       = 1'b1;
                        emit_write = 1'b1;
                     end
                  end
                  rwlm_pkg::OP_RELEASE: begin
                     if (rc_ff > 8'd1) begin
                        rc_in = rc_ff - 1'b1;
                     end else begin
                        rc_in   = '0;
                        mode_in = rwlm_pkg::MODE_FREE;
                        if (nonempty) begin
                           head_in  = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                                      head_ff + 1'b1;
                           count_in = count_ff - 1'b1;
                           if (head_kind) begin
                              mode_in    = rwlm_pkg::MODE_WRITE;
                              emit       = 1'b1;
                              emit_write = 1'b1;
                              emit_task  = head_task;
                           end else begin
                              rc_in   = 8'd1;
                              mode_in = rwlm_pkg::MODE_READ;
                              pend_in = head_task;
                              go_wake = 1'b1;
                           end
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               if (mem_we) begin
                  tail_in  = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
         end
         rwlm_pkg::ST_WAKE: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_task = pend_ff;
               emit_last = !wake_more;
               if (wake_more) begin
                  head_in  = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
                  count_in = count_ff - 1'b1;
                  rc_in    = rc_ff + 1'b1;
                  pend_in  = head_task;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_task_in    = rsp_task_ff;
      rsp_write_in   = rsp_write_ff;
      rsp_refused_in = rsp_refused_ff;
      rsp_last_in    = rsp_last_ff;
      if (emit) begin
         rsp_valid_in   = 1'b1;
         rsp_task_in    = emit_task;
         rsp_write_in   = emit_write;
         rsp_refused_in = emit_refused;
         rsp_last_in    = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rwlm_pkg::ST_IDLE;
         mode_ff      <= rwlm_pkg::MODE_FREE;
         rc_ff        <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rc_ff        <= rc_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      task_ff        <= task_in;
      pend_ff        <= pend_in;
      rsp_task_ff    <= rsp_task_in;
      rsp_write_ff   <= rsp_write_in;
      rsp_refused_ff <= rsp_refused_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_tready = state_ff == rwlm_pkg::ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_task_ff);
   assign rsp_tuser  = {rsp_refused_ff, rsp_write_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("waiting queue count exceeds its depth");

   a_readers_match_mode: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == rwlm_pkg::MODE_READ) == (rc_ff != '0))
      else $error("reader count disagrees with lock mode");

   a_wake_in_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == rwlm_pkg::ST_WAKE |-> mode_ff == rwlm_pkg::MODE_READ)
      else $error("readers woken while the lock is not held for reading");

endmodule
